// File: rtl/trs_pkg.sv
// Shared types, constants and a helper function for the triangle scanline rasterizer.
package trs_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int SLOPE_W    = 32;
	localparam int XOUT_W     = 16;
	localparam int DIV_W      = COORD_BITS + FRAC_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0]   delta_t;
	typedef logic signed [SLOPE_W-1:0]    fixed_t;

	// One command passed from the front part to the back part.
	typedef struct packed {
		logic   is_load;
		logic   front_facing;
		coord_t xa;
		coord_t ya;
		coord_t xb;
		coord_t yb;
		coord_t xc;
		coord_t yc;
	} cmd_t;

	// Converts a screen coordinate to fixed point.
	function automatic fixed_t to_fixed(input coord_t v);
		fixed_t t;
		t = SLOPE_W'(v);
		return t <<< FRAC_BITS;
	endfunction

endpackage

// File: rtl/trs_front.sv
// Front part: accepts transactions, computes the facing test and sorts vertices by y.
module trs_front import trs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  logic   req_type,
	input  coord_t vtx0_x,
	input  coord_t vtx0_y,
	input  coord_t vtx1_x,
	input  coord_t vtx1_y,
	input  coord_t vtx2_x,
	input  coord_t vtx2_y,
	output logic   push,
	output cmd_t   push_cmd,
	input  logic   fifo_full
);

	localparam int PROD_W = 2 * (COORD_BITS + 1);

	logic v1_q, v2_q;
	logic type_s1, type_s2;
	coord_t x0_s1, y0_s1, x1_s1, y1_s1, x2_s1, y2_s1;
	coord_t x0_s2, y0_s2, x1_s2, y1_s2, x2_s2, y2_s2;
	logic signed [PROD_W-1:0] p1_s2, p2_s2;
	logic signed [PROD_W:0] area;
	logic adv1, adv2;

	assign push     = v2_q && !fifo_full;
	assign adv2     = !v2_q || !fifo_full;
	assign adv1     = !v1_q || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= in_valid;
			if (adv2) v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			type_s1 <= req_type;
			x0_s1 <= vtx0_x; y0_s1 <= vtx0_y;
			x1_s1 <= vtx1_x; y1_s1 <= vtx1_y;
			x2_s1 <= vtx2_x; y2_s1 <= vtx2_y;
		end
		if (adv2 && v1_q) begin
			type_s2 <= type_s1;
			x0_s2 <= x0_s1; y0_s2 <= y0_s1;
			x1_s2 <= x1_s1; y1_s2 <= y1_s1;
			x2_s2 <= x2_s1; y2_s2 <= y2_s1;
			// The two products of the cross product of the edge vectors; their difference is the signed parallelogram area.
			p1_s2 <= PROD_W'((delta_t'(x1_s1) - delta_t'(x0_s1)) *
				(delta_t'(y2_s1) - delta_t'(y0_s1)));
			p2_s2 <= PROD_W'((delta_t'(x2_s1) - delta_t'(x0_s1)) *
				(delta_t'(y1_s1) - delta_t'(y0_s1)));
		end
	end

	always_comb begin
		area = (PROD_W+1)'(p1_s2) - (PROD_W+1)'(p2_s2);
		push_cmd = '0;
		push_cmd.is_load      = !type_s2;
		push_cmd.front_facing = area[PROD_W];
		if (y0_s2 <= y1_s2) begin
			if (y0_s2 <= y2_s2) begin
				if (y1_s2 <= y2_s2) begin
					push_cmd.xa = x0_s2; push_cmd.ya = y0_s2;
					push_cmd.xb = x1_s2; push_cmd.yb = y1_s2;
					push_cmd.xc = x2_s2; push_cmd.yc = y2_s2;
				end else begin
					push_cmd.xa = x0_s2; push_cmd.ya = y0_s2;
					push_cmd.xb = x2_s2; push_cmd.yb = y2_s2;
					push_cmd.xc = x1_s2; push_cmd.yc = y1_s2;
				end
			end else begin
				push_cmd.xa = x2_s2; push_cmd.ya = y2_s2;
				push_cmd.xb = x0_s2; push_cmd.yb = y0_s2;
				push_cmd.xc = x1_s2; push_cmd.yc = y1_s2;
			end
		end else if (y1_s2 > y2_s2) begin
			push_cmd.xa = x2_s2; push_cmd.ya = y2_s2;
			push_cmd.xb = x1_s2; push_cmd.yb = y1_s2;
			push_cmd.xc = x0_s2; push_cmd.yc = y0_s2;
		end else if (y0_s2 <= y2_s2) begin
			push_cmd.xa = x1_s2; push_cmd.ya = y1_s2;
			push_cmd.xb = x0_s2; push_cmd.yb = y0_s2;
			push_cmd.xc = x2_s2; push_cmd.yc = y2_s2;
		end else begin
			push_cmd.xa = x1_s2; push_cmd.ya = y1_s2;
			push_cmd.xb = x2_s2; push_cmd.yb = y2_s2;
			push_cmd.xc = x0_s2; push_cmd.yc = y0_s2;
		end
	end

endmodule

// File: rtl/trs_cmd_fifo.sv
// Short command queue between the front and back parts.
module trs_cmd_fifo import trs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	cmd_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0] cnt_q;

	assign full      = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

endmodule

// File: rtl/trs_div.sv
// Bit-serial restoring divider that forms one fixed-point edge slope.
module trs_div import trs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  delta_t                dx,
	input  logic [COORD_BITS-1:0] dy,
	output logic                  done,
	output fixed_t                slope
);

	logic busy_q, done_q, neg_q, zero_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [COORD_BITS-1:0] rem_q, dy_q;
	logic [DIV_W-1:0] acc_q;
	delta_t dx_q;
	logic [COORD_BITS:0] rsh, rdiff;
	logic ge;
	logic [COORD_BITS:0] dx_mag;
	fixed_t mag, dx_fx;

	assign dx_mag = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
	assign rsh    = {rem_q, acc_q[DIV_W-1]};
	assign ge     = rsh >= {1'b0, dy_q};
	assign rdiff  = rsh - {1'b0, dy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= {dx_mag[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			dy_q   <= dy;
			dx_q   <= dx;
			neg_q  <= dx[COORD_BITS];
			zero_q <= (dy == '0);
		end else if (busy_q) begin
			acc_q <= {acc_q[DIV_W-2:0], ge};
			rem_q <= ge ? rdiff[COORD_BITS-1:0] : rsh[COORD_BITS-1:0];
		end
	end

	always_comb begin
		mag   = SLOPE_W'(acc_q);
		dx_fx = SLOPE_W'(dx_q) <<< FRAC_BITS;
		if (zero_q)     slope = dx_fx;
		else if (neg_q) slope = -mag;
		else            slope = mag;
	end

	assign done = done_q;

endmodule

// File: rtl/trs_back.sv
// Back part: runs slope setup for front-facing loads and walks spans, holding the result register.
module trs_back import trs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              accepted,
	output logic              span_valid,
	output coord_t            span_y,
	output logic [XOUT_W-1:0] span_x_start,
	output logic [XOUT_W-1:0] span_x_end,
	output logic              last_span
);

	typedef enum logic [1:0] {
		B_RUN = 2'b01,
		B_DIV = 2'b10
	} bstate_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_UPPER = 3'b010,
		PH_LOWER = 3'b100
	} phase_t;

	bstate_t state_q;
	phase_t  phase_q;
	logic [1:0] idx_q;
	logic wait_q;
	coord_t xa_q, ya_q, xb_q, yb_q, xc_q, yc_q, row_q;
	fixed_t sx_q, lx_q, ss_q, ls_q, low_q;
	logic out_valid_q;
	logic div_start, div_done;
	delta_t div_dx, div_dy;
	fixed_t div_slope;
	logic is_last;

	function automatic logic [XOUT_W-1:0] trunc_x(input fixed_t v);
		logic [SLOPE_W-1:0] m;
		m = v[SLOPE_W-1] ? SLOPE_W'(-v) : SLOPE_W'(v);
		m = m >> FRAC_BITS;
		if (v[SLOPE_W-1]) m = -m;
		return m[XOUT_W-1:0];
	endfunction

	assign pop       = cmd_valid && (state_q == B_RUN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign div_start = (state_q == B_DIV) && !wait_q;
	assign is_last   = (phase_q == PH_LOWER) && (row_q == yc_q);

	always_comb begin
		case (idx_q)
			2'd0: begin
				div_dx = delta_t'(xc_q) - delta_t'(xa_q);
				div_dy = delta_t'(yc_q) - delta_t'(ya_q);
			end
			2'd1: begin
				div_dx = delta_t'(xb_q) - delta_t'(xa_q);
				div_dy = delta_t'(yb_q) - delta_t'(ya_q);
			end
			default: begin
				div_dx = delta_t'(xc_q) - delta_t'(xb_q);
				div_dy = delta_t'(yc_q) - delta_t'(yb_q);
			end
		endcase
	end

	trs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.dx    (div_dx),
		.dy    (div_dy[COORD_BITS-1:0]),
		.done  (div_done),
		.slope (div_slope)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_RUN;
			phase_q     <= PH_IDLE;
			idx_q       <= '0;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				B_RUN: begin
					if (pop) begin
						out_valid_q <= 1'b1;
						if (cmd.is_load) begin
							if (!cmd.front_facing) begin
								phase_q <= PH_IDLE;
							end else begin
								phase_q <= (cmd.ya < cmd.yb) ? PH_UPPER : PH_LOWER;
								state_q <= B_DIV;
								idx_q   <= '0;
								wait_q  <= 1'b0;
							end
						end else if (phase_q == PH_UPPER) begin
							if (row_q + 1'b1 == yb_q) phase_q <= PH_LOWER;
						end else if (phase_q == PH_LOWER) begin
							if (is_last) phase_q <= PH_IDLE;
						end
					end
				end
				B_DIV: begin
					if (div_start) wait_q <= 1'b1;
					if (div_done) begin
						wait_q <= 1'b0;
						idx_q  <= idx_q + 1'b1;
						if (idx_q == 2'd2) state_q <= B_RUN;
					end
				end
				default: state_q <= B_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			accepted     <= 1'b0;
			span_valid   <= 1'b0;
			span_y       <= '0;
			span_x_start <= '0;
			span_x_end   <= '0;
			last_span    <= 1'b0;
			if (cmd.is_load) begin
				accepted <= cmd.front_facing;
				if (cmd.front_facing) begin
					xa_q <= cmd.xa; ya_q <= cmd.ya;
					xb_q <= cmd.xb; yb_q <= cmd.yb;
					xc_q <= cmd.xc; yc_q <= cmd.yc;
					lx_q <= to_fixed(cmd.xa);
					if (cmd.ya < cmd.yb) begin
						sx_q  <= to_fixed(cmd.xa);
						row_q <= cmd.ya;
					end else begin
						sx_q  <= to_fixed(cmd.xb);
						row_q <= cmd.yb;
					end
				end
			end else if (phase_q != PH_IDLE) begin
				span_valid   <= 1'b1;
				span_y       <= row_q;
				span_x_start <= trunc_x(sx_q);
				span_x_end   <= trunc_x(lx_q);
				last_span    <= is_last;
				lx_q         <= lx_q + ls_q;
				row_q        <= row_q + 1'b1;
				if ((phase_q == PH_UPPER) && (row_q + 1'b1 == yb_q)) begin
					// Short edge restarts at the middle vertex.
					sx_q <= to_fixed(xb_q);
					ss_q <= low_q;
				end else begin
					sx_q <= sx_q + ss_q;
				end
			end
		end
		if ((state_q == B_DIV) && div_done) begin
			case (idx_q)
				2'd0: ls_q <= div_slope;
				2'd1: begin
					if (phase_q == PH_UPPER) ss_q <= div_slope;
				end
				default: begin
					low_q <= div_slope;
					if (phase_q == PH_LOWER) ss_q <= div_slope;
				end
			endcase
		end
	end

endmodule

// File: rtl/triangle_scanline_rasterizer_unit.sv
// Top level of the triangle scanline rasterizer: front part, command queue and back part.
//
// A transaction with req_type 0 loads a triangle and yields one result whose accepted bit
// tells whether it faces the viewer; a transaction with req_type 1 yields the next span
// (row, short edge x, long edge x, last flag), or span_valid 0 when no triangle is pending.
// The front part takes a transaction every cycle while the four-entry command queue has
// room, and passes each transaction through the s1 and s2 pipeline registers for the area
// products and the y sort. The back part registers the answer to a span request as it pops
// it from the queue. An accepted load returns its result at once but then holds the back
// part for three slope divisions on one shared bit-serial divider; later requests wait in
// the queue meanwhile. The result register lets a new transaction be taken while a finished
// result still waits for the consumer.
module triangle_scanline_rasterizer_unit import trs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  coord_t            vtx0_x,
	input  coord_t            vtx0_y,
	input  coord_t            vtx1_x,
	input  coord_t            vtx1_y,
	input  coord_t            vtx2_x,
	input  coord_t            vtx2_y,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              accepted,
	output logic              span_valid,
	output coord_t            span_y,
	output logic [XOUT_W-1:0] span_x_start,
	output logic [XOUT_W-1:0] span_x_end,
	output logic              last_span
);

	logic push, full, pop, not_empty;
	cmd_t push_cmd, head;

	// Classifies each transaction and sorts the vertices of a load.
	trs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.vtx0_x   (vtx0_x),
		.vtx0_y   (vtx0_y),
		.vtx1_x   (vtx1_x),
		.vtx1_y   (vtx1_y),
		.vtx2_x   (vtx2_x),
		.vtx2_y   (vtx2_y),
		.push     (push),
		.push_cmd (push_cmd),
		.fifo_full(full)
	);

	// Commands keep their order through the queue, so spans follow their load.
	trs_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.not_empty(not_empty),
		.head     (head)
	);

	// Sets up edge slopes and walks the spans.
	trs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (not_empty),
		.cmd         (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.accepted    (accepted),
		.span_valid  (span_valid),
		.span_y      (span_y),
		.span_x_start(span_x_start),
		.span_x_end  (span_x_end),
		.last_span   (last_span)
	);

endmodule
